[hw/rtl/matrix3_inverse_macros.svh]
// assertion macros for the matrix3_inverse block
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// same-cycle implication on clk_i, disabled while rst_ni is low
`define M3I_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("m3inv check failed");

// next-cycle implication
`define M3I_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("m3inv check failed");

// implication after a constant number of cycles
`define M3I_ASSERT_LAT(lbl, ant, n, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> ##n (con)) \
    else $error("m3inv latency check failed");

`endif

[hw/rtl/m3inv_pkg.sv]
// types and constants for the 3x3 matrix inverse
package m3inv_pkg;

  localparam int ELEM_W = 32;
  localparam int TOL_W  = 31;
  localparam int NELEM  = 9;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [TOL_W-1:0]         tol_t;
  typedef logic [3:0]               idx_t;

  // adjugate entry i = e[A]*e[B] - e[C]*e[D], elements indexed row*3+col
  localparam idx_t COF_A [NELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam idx_t COF_B [NELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam idx_t COF_C [NELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam idx_t COF_D [NELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

[hw/rtl/matrix3_inverse.sv]
// 3x3 fixed-point matrix inverse by adjugate and pipelined long division
//
// Usage: drive a00_i..a22_i with a signed matrix and pulse start_i; an item
// is taken at every clock edge where start_i is high and busy_o is low.
// busy_o stays low, so a new matrix may enter in every cycle.
// singular_tolerance_i is written when cfg_we_i is high; the user must do so
// only while idle, as the block does not enforce it. Each result appears on
// r00_o..r22_o and invertible_o for one cycle with done_o high.
// Throughput is one item per cycle: 8 stages form products, cofactors, the
// determinant and the numerators, then 33 restoring-division stages resolve
// one quotient bit each for all nine entries, and one stage saturates.
// A determinant magnitude at or below the tolerance gives all zeros with
// invertible_o low. Quotients beyond the signed 32-bit range saturate.
// Reset clears all stage valid bits and the tolerance register; items in
// flight are dropped. The receiver cannot stall, so no result is ever held
// back; results simply follow one another in input order.
module matrix3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                cfg_we_i,
  input  m3inv_pkg::tol_t     singular_tolerance_i,
  input  m3inv_pkg::elem_t    a00_i,
  input  m3inv_pkg::elem_t    a01_i,
  input  m3inv_pkg::elem_t    a02_i,
  input  m3inv_pkg::elem_t    a10_i,
  input  m3inv_pkg::elem_t    a11_i,
  input  m3inv_pkg::elem_t    a12_i,
  input  m3inv_pkg::elem_t    a20_i,
  input  m3inv_pkg::elem_t    a21_i,
  input  m3inv_pkg::elem_t    a22_i,
  output logic                done_o,
  output m3inv_pkg::elem_t    r00_o,
  output m3inv_pkg::elem_t    r01_o,
  output m3inv_pkg::elem_t    r02_o,
  output m3inv_pkg::elem_t    r10_o,
  output m3inv_pkg::elem_t    r11_o,
  output m3inv_pkg::elem_t    r12_o,
  output m3inv_pkg::elem_t    r20_o,
  output m3inv_pkg::elem_t    r21_o,
  output m3inv_pkg::elem_t    r22_o,
  output logic                invertible_o
);
  import m3inv_pkg::*;
`include "matrix3_inverse_macros.svh"

  localparam int PW    = 2 * ELEM_W;
  localparam int CW    = PW + 1;
  localparam int MW    = PW;
  localparam int DW    = 96;
  localparam int DETW  = DW + 2;
  localparam int NSH   = 2 * FRAC_BITS + 1;
  localparam int NW0   = (MW + NSH > DW) ? MW + NSH : DW;
  localparam int NW    = NW0 + 1;
  localparam int DSTG  = ELEM_W + 1;
  localparam int XW0   = DW + 1 + DSTG;
  localparam int XW    = (NW > XW0) ? NW : XW0;
  localparam int SW    = (TOL_W + 2 * FRAC_BITS > DW) ? TOL_W + 2 * FRAC_BITS : DW;
  localparam int LATENCY = 8 + DSTG + 1;

  tol_t tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= singular_tolerance_i;
    end
  end

  assign busy_o = 1'b0;

  elem_t elem [NELEM];
  assign elem[0] = a00_i;
  assign elem[1] = a01_i;
  assign elem[2] = a02_i;
  assign elem[3] = a10_i;
  assign elem[4] = a11_i;
  assign elem[5] = a12_i;
  assign elem[6] = a20_i;
  assign elem[7] = a21_i;
  assign elem[8] = a22_i;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic vd_q [DSTG+1];
  logic done_q;

  // front stages
  logic signed [PW-1:0] pa1_q [NELEM];
  logic signed [PW-1:0] pb1_q [NELEM];
  elem_t                e1_q  [3];
  logic signed [CW-1:0] cof2_q [NELEM];
  elem_t                e2_q   [3];
  logic [MW-1:0]        cmag3_q [NELEM];
  logic                 cneg3_q [NELEM];
  logic [ELEM_W-1:0]    emag3_q [3];
  logic                 eneg3_q [3];
  logic [MW-1:0]        cmag4_q [NELEM];
  logic                 cneg4_q [NELEM];
  logic [PW-1:0]        pl4_q [3];
  logic [PW-1:0]        ph4_q [3];
  logic                 tneg4_q [3];
  logic [MW-1:0]        cmag5_q [NELEM];
  logic                 cneg5_q [NELEM];
  logic [DW-1:0]        tmag5_q [3];
  logic                 tneg5_q [3];
  logic [MW-1:0]        cmag6_q [NELEM];
  logic                 cneg6_q [NELEM];
  logic signed [DETW-1:0] det6_q;
  logic [MW-1:0]        cmag7_q [NELEM];
  logic                 cneg7_q [NELEM];
  logic [DW-1:0]        dmag7_q;
  logic                 dneg7_q;

  // division stages, index 0 is loaded from the front end
  logic [NW-1:0]        rem_q  [DSTG+1][NELEM];
  logic [DSTG-1:0]      quo_q  [DSTG+1][NELEM];
  logic                 qneg_q [DSTG+1][NELEM];
  logic                 sing_q [DSTG+1];
  logic [DW:0]          div_q  [DSTG+1];

  elem_t                r_q [NELEM];
  logic                 inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      done_q <= 1'b0;
      for (int j = 0; j <= DSTG; j++) begin
        vd_q[j] <= 1'b0;
      end
    end else begin
      v1_q     <= start_i & ~busy_o;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      v6_q     <= v5_q;
      v7_q     <= v6_q;
      vd_q[0]  <= v7_q;
      for (int j = 0; j < DSTG; j++) begin
        vd_q[j+1] <= vd_q[j];
      end
      done_q   <= vd_q[DSTG];
    end
  end

  // element products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NELEM; i++) begin
      pa1_q[i] <= elem[COF_A[i]] * elem[COF_B[i]];
      pb1_q[i] <= elem[COF_C[i]] * elem[COF_D[i]];
    end
    e1_q[0] <= a00_i;
    e1_q[1] <= a10_i;
    e1_q[2] <= a20_i;
  end

  // cofactors
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NELEM; i++) begin
      cof2_q[i] <= CW'(pa1_q[i]) - CW'(pb1_q[i]);
    end
    for (int i = 0; i < 3; i++) begin
      e2_q[i] <= e1_q[i];
    end
  end

  // magnitudes and signs
  logic [CW-1:0]     cu [NELEM];
  logic [ELEM_W-1:0] eu [3];

  always_comb begin
    for (int i = 0; i < NELEM; i++) begin
      cu[i] = cof2_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      eu[i] = e2_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NELEM; i++) begin
      cmag3_q[i] <= cu[i][CW-1] ? MW'(~cu[i] + CW'(1)) : cu[i][MW-1:0];
      cneg3_q[i] <= cu[i][CW-1];
    end
    for (int i = 0; i < 3; i++) begin
      emag3_q[i] <= eu[i][ELEM_W-1] ? (~eu[i] + ELEM_W'(1)) : eu[i];
      eneg3_q[i] <= eu[i][ELEM_W-1];
    end
  end

  // determinant partial products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pl4_q[i]   <= PW'(cmag3_q[i][ELEM_W-1:0]) * PW'(emag3_q[i]);
      ph4_q[i]   <= PW'(cmag3_q[i][MW-1:ELEM_W]) * PW'(emag3_q[i]);
      tneg4_q[i] <= cneg3_q[i] ^ eneg3_q[i];
    end
    for (int i = 0; i < NELEM; i++) begin
      cmag4_q[i] <= cmag3_q[i];
      cneg4_q[i] <= cneg3_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      tmag5_q[i] <= {ph4_q[i], {ELEM_W{1'b0}}} + {{ELEM_W{1'b0}}, pl4_q[i]};
      tneg5_q[i] <= tneg4_q[i];
    end
    for (int i = 0; i < NELEM; i++) begin
      cmag5_q[i] <= cmag4_q[i];
      cneg5_q[i] <= cneg4_q[i];
    end
  end

  // signed determinant sum
  logic [DETW-1:0] tsum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = tneg5_q[i] ? (~DETW'(tmag5_q[i]) + DETW'(1)) : DETW'(tmag5_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    det6_q <= tsum[0] + tsum[1] + tsum[2];
    for (int i = 0; i < NELEM; i++) begin
      cmag6_q[i] <= cmag5_q[i];
      cneg6_q[i] <= cneg5_q[i];
    end
  end

  logic [DETW-1:0] du;
  assign du = det6_q;

  always_ff @(posedge clk_i) begin
    dmag7_q <= du[DETW-1] ? DW'(~du + DETW'(1)) : du[DW-1:0];
    dneg7_q <= du[DETW-1];
    for (int i = 0; i < NELEM; i++) begin
      cmag7_q[i] <= cmag6_q[i];
      cneg7_q[i] <= cneg6_q[i];
    end
  end

  // singular test and rounded numerators
  logic [SW-1:0] tol_sh;
  assign tol_sh = SW'(tol_q) << (2 * FRAC_BITS);

  always_ff @(posedge clk_i) begin
    sing_q[0] <= tol_sh >= SW'(dmag7_q);
    div_q[0]  <= {dmag7_q, 1'b0};
    for (int i = 0; i < NELEM; i++) begin
      rem_q[0][i]  <= (NW'(cmag7_q[i]) << NSH) + NW'(dmag7_q);
      quo_q[0][i]  <= '0;
      qneg_q[0][i] <= cneg7_q[i] ^ dneg7_q;
    end
  end

  // one quotient bit per stage, highest bit first
  for (genvar j = 0; j < DSTG; j++) begin : g_div
    localparam int K = DSTG - 1 - j;
    logic [XW-1:0] dsh;
    logic [XW-1:0] rx  [NELEM];
    logic          ge  [NELEM];

    assign dsh = XW'(div_q[j]) << K;

    always_comb begin
      for (int i = 0; i < NELEM; i++) begin
        rx[i] = XW'(rem_q[j][i]);
        ge[i] = rx[i] >= dsh;
      end
    end

    always_ff @(posedge clk_i) begin
      sing_q[j+1] <= sing_q[j];
      div_q[j+1]  <= div_q[j];
      for (int i = 0; i < NELEM; i++) begin
        rem_q[j+1][i]  <= ge[i] ? NW'(rx[i] - dsh) : rem_q[j][i];
        quo_q[j+1][i]  <= quo_q[j][i] | (DSTG'(ge[i]) << K);
        qneg_q[j+1][i] <= qneg_q[j][i];
      end
    end
  end

  // saturation and sign
  logic [DSTG-1:0]   qf [NELEM];
  logic [ELEM_W-1:0] rs [NELEM];

  always_comb begin
    for (int i = 0; i < NELEM; i++) begin
      qf[i] = quo_q[DSTG][i];
      if (sing_q[DSTG]) begin
        rs[i] = '0;
      end else if (!qneg_q[DSTG][i]) begin
        rs[i] = (qf[i] > DSTG'(SAT_POS)) ? SAT_POS : qf[i][ELEM_W-1:0];
      end else begin
        rs[i] = (qf[i] > DSTG'(SAT_NEG)) ? SAT_NEG : (~qf[i][ELEM_W-1:0] + ELEM_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NELEM; i++) begin
        r_q[i] <= '0;
      end
      inv_q <= 1'b0;
    end else if (vd_q[DSTG]) begin
      for (int i = 0; i < NELEM; i++) begin
        r_q[i] <= rs[i];
      end
      inv_q <= ~sing_q[DSTG];
    end
  end

  assign done_o       = done_q;
  assign r00_o        = r_q[0];
  assign r01_o        = r_q[1];
  assign r02_o        = r_q[2];
  assign r10_o        = r_q[3];
  assign r11_o        = r_q[4];
  assign r12_o        = r_q[5];
  assign r20_o        = r_q[6];
  assign r21_o        = r_q[7];
  assign r22_o        = r_q[8];
  assign invertible_o = inv_q;

  `M3I_ASSERT_LAT(a_latency, start_i && !busy_o, LATENCY, done_o)
  `M3I_ASSERT_NOW(a_sing_zero, done_o && !invertible_o, r00_o == '0 && r11_o == '0 && r22_o == '0)
  `M3I_ASSERT_NEXT(a_hold, !vd_q[DSTG], $stable(r00_o) && $stable(invertible_o))

endmodule

[verif/tb.sv]
// testbench for matrix3_inverse: queued matrices, self-checking against a local inverse predictor
module tb;
  import m3inv_pkg::*;

  typedef struct {
    elem_t a [9];
  } matrix_t;

  typedef struct {
    elem_t r [9];
    logic  inv;
  } inverse_t;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam int WATCHDOG_LIMIT = 5000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  logic  cfg_we_i = 1'b0;
  tol_t  singular_tolerance_i = '0;
  elem_t a_i [9];
  logic  busy_o, done_o, invertible_o;
  elem_t r_o [9];

  matrix_t  pending_items [$];
  inverse_t expected_inverses [$];
  tol_t     tolerance_model = '0;
  int       gap_left = 0;
  bit       burst = 1'b0;
  bit       took_q = 1'b0;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  matrix3_inverse i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .singular_tolerance_i,
    .a00_i(a_i[0]), .a01_i(a_i[1]), .a02_i(a_i[2]),
    .a10_i(a_i[3]), .a11_i(a_i[4]), .a12_i(a_i[5]),
    .a20_i(a_i[6]), .a21_i(a_i[7]), .a22_i(a_i[8]),
    .done_o,
    .r00_o(r_o[0]), .r01_o(r_o[1]), .r02_o(r_o[2]),
    .r10_o(r_o[3]), .r11_o(r_o[4]), .r12_o(r_o[5]),
    .r20_o(r_o[6]), .r21_o(r_o[7]), .r22_o(r_o[8]),
    .invertible_o
  );

  function automatic logic signed [127:0] cof_prod(elem_t p, elem_t q, elem_t r, elem_t s);
    logic signed [127:0] pw, qw, rw, sw;
    pw = p;
    qw = q;
    rw = r;
    sw = s;
    return pw * qw - rw * sw;
  endfunction

  function automatic inverse_t invert_matrix(matrix_t m, tol_t tol);
    inverse_t res;
    logic signed [127:0] adj [9];
    logic signed [127:0] det, e0, e1, e2;
    logic [127:0] dmag, cmag, q, tol_w;
    bit neg;
    adj[0] = cof_prod(m.a[4], m.a[8], m.a[5], m.a[7]);
    adj[1] = cof_prod(m.a[2], m.a[7], m.a[1], m.a[8]);
    adj[2] = cof_prod(m.a[1], m.a[5], m.a[2], m.a[4]);
    adj[3] = cof_prod(m.a[5], m.a[6], m.a[3], m.a[8]);
    adj[4] = cof_prod(m.a[0], m.a[8], m.a[2], m.a[6]);
    adj[5] = cof_prod(m.a[2], m.a[3], m.a[0], m.a[5]);
    adj[6] = cof_prod(m.a[3], m.a[7], m.a[4], m.a[6]);
    adj[7] = cof_prod(m.a[1], m.a[6], m.a[0], m.a[7]);
    adj[8] = cof_prod(m.a[0], m.a[4], m.a[1], m.a[3]);
    e0 = m.a[0];
    e1 = m.a[3];
    e2 = m.a[6];
    det = e0 * adj[0] + e1 * adj[1] + e2 * adj[2];
    dmag = det[127] ? -det : det;
    tol_w = {97'd0, tol} << 32;
    res.inv = 1'b0;
    for (int i = 0; i < 9; i++) res.r[i] = '0;
    if (tol_w < dmag) begin
      res.inv = 1'b1;
      for (int i = 0; i < 9; i++) begin
        cmag = adj[i][127] ? -adj[i] : adj[i];
        q = ((cmag << 33) + dmag) / (dmag << 1);
        neg = adj[i][127] != det[127];
        if (!neg) res.r[i] = (q > 128'h7FFF_FFFF) ? SAT_POS : q[31:0];
        else res.r[i] = (q > 128'h8000_0000) ? SAT_NEG : -q[31:0];
      end
    end
    return res;
  endfunction

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 8 * ONE)) - $signed(4 * ONE);
      2: return $signed($urandom_range(0, 64)) - 32;
      default: begin
        case ($urandom_range(0, 4))
          0: return SAT_NEG;
          1: return SAT_POS;
          2: return '0;
          3: return ONE;
          default: return -ONE;
        endcase
      end
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int mode, k;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      m.a[i] = rand_elem(mode < 2 ? 0 : mode < 6 ? 1 : mode < 8 ? 2 : 3);
    end
    if (mode == 5) begin
      // second row is a multiple of the first: singular
      k = $urandom_range(0, 4) - 2;
      for (int c = 0; c < 3; c++) m.a[3 + c] = m.a[c] * k;
    end else if (mode == 4) begin
      for (int c = 0; c < 3; c++) m.a[3 * c + c] = m.a[3 * c + c] + 8 * ONE;
    end
    return m;
  endfunction

  function automatic matrix_t diag(elem_t d0, elem_t d1, elem_t d2);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.a[i] = '0;
    m.a[0] = d0;
    m.a[4] = d1;
    m.a[8] = d2;
    return m;
  endfunction

  function automatic matrix_t fill(elem_t v);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.a[i] = v;
    return m;
  endfunction

  task automatic set_tolerance(tol_t v);
    while (pending_items.size() != 0 || expected_inverses.size() != 0 || start_i)
      @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    singular_tolerance_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) pending_items.push_back(random_matrix());
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!start_i || took_q) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (pending_items.size() != 0 && !cfg_we_i) begin
        matrix_t m;
        m = pending_items.pop_front();
        for (int i = 0; i < 9; i++) a_i[i] <= m.a[i];
        start_i <= 1'b1;
        if ($urandom_range(0, 15) == 0) burst <= ~burst;
        gap_left <= burst ? 0 : $urandom_range(0, 17);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    inverse_t exp_r;
    matrix_t  m;
    took_q <= start_i && !busy_o && rst_ni;
    if (cfg_we_i) tolerance_model <= singular_tolerance_i;
    if (rst_ni && start_i && !busy_o) begin
      for (int i = 0; i < 9; i++) m.a[i] = a_i[i];
      expected_inverses.push_back(invert_matrix(m, tolerance_model));
    end
    if (rst_ni && done_o) begin
      if (expected_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item");
      end else begin
        exp_r = expected_inverses.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (r_o[i] !== exp_r.r[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("r%0d%0d: expected %h actual %h", i / 3, i % 3, exp_r.r[i], r_o[i]);
          end
        end
        if (invertible_o !== exp_r.inv) begin
          mismatches++;
          if (mismatches <= 10)
            $display("invertible: expected %b actual %b", exp_r.inv, invertible_o);
        end
      end
    end
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 9; i++) a_i[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    set_tolerance('0);
    pending_items.push_back(diag(ONE, ONE, ONE));
    pending_items.push_back(fill('0));
    pending_items.push_back(fill(SAT_POS));
    pending_items.push_back(fill(SAT_NEG));
    pending_items.push_back(diag(SAT_NEG, SAT_NEG, SAT_NEG));
    pending_items.push_back(diag(SAT_POS, SAT_NEG, SAT_POS));
    pending_items.push_back(diag(2 * ONE, ONE / 2, -ONE));
    pending_items.push_back(diag(1, 1, 1));
    pending_items.push_back(diag(-1, 1, 1));
    pending_items.push_back(diag(3 * ONE, 3 * ONE, 3 * ONE));
    pending_items.push_back(diag(ONE, ONE, '0));
    push_random(400);

    set_tolerance(31'h7FFF_FFFF);
    pending_items.push_back(diag(SAT_NEG, SAT_NEG, SAT_NEG));
    pending_items.push_back(diag(ONE, ONE, ONE));
    push_random(200);

    set_tolerance(31'd1);
    pending_items.push_back(diag(1, 1, 1));
    pending_items.push_back(diag(2, 1, 1));
    push_random(300);

    set_tolerance(31'(ONE));
    pending_items.push_back(diag(ONE, ONE, ONE));
    pending_items.push_back(diag(ONE, ONE, ONE + 1));
    push_random(300);

    set_tolerance(31'($urandom_range(0, 8 * ONE)));
    push_random(400);

    while (pending_items.size() != 0 || expected_inverses.size() != 0 || start_i)
      @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/m3inv_pkg.sv
hw/rtl/matrix3_inverse.sv
verif/tb.sv
